[design/stxrx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stxrx_pkg
// Types and constants shared by the framed packet receiver modules.
// ----------------------------------------------------------------------------
package stxrx_pkg;

	localparam int unsigned CfgDataWidth = 16;
	localparam int unsigned CfgIndexWidth = 2;
	localparam int unsigned CountWidth = 32;
	localparam int unsigned LengthWidth = 7;
	localparam int unsigned IndexWidth = 6;

	// configuration register indexes
	localparam logic [CfgIndexWidth-1:0] CFG_START_MARKER = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_END_MARKER = 2'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_TIMEOUT_LIMIT = 2'd2;

	// configuration reset values
	localparam logic [7:0] START_MARKER_RST = 8'd2;
	localparam logic [7:0] END_MARKER_RST = 8'd3;
	localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd100;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_BYTE = 3'd0,
		KIND_EMPTY = 3'd1,
		KIND_CHKERR = 3'd2,
		KIND_BADEND = 3'd3,
		KIND_OVERRUN = 3'd4,
		KIND_TIMEOUT = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_CMD = 3'd1,
		PH_LEN = 3'd2,
		PH_DATA = 3'd3,
		PH_CHK = 3'd4,
		PH_END = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		SQ_IDLE = 2'd0,
		SQ_EXEC = 2'd1,
		SQ_READ = 2'd2,
		SQ_EMIT = 2'd3
	} seq_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] command;
		logic [LengthWidth-1:0] length;
		logic [IndexWidth-1:0] byte_index;
		logic [7:0] payload_byte;
		logic last;
		logic [CountWidth-1:0] received_count;
		logic [CountWidth-1:0] checksum_error_count;
		logic [CountWidth-1:0] timeout_count;
		logic [CountWidth-1:0] overrun_count;
	} rx_result_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic start_pkt;
		logic load_cmd;
		logic load_len;
		logic write_data;
		logic load_chk;
		logic tick_inc;
		logic inc_good;
		logic inc_chkerr;
		logic inc_timeout;
		logic inc_overrun;
		logic clear_stats;
		logic rd_start;
		logic rd_next;
		logic out_load;
		kind_t out_kind;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] operation;
		logic byte_is_start;
		logic byte_is_end;
		logic byte_over;
		logic byte_zero;
		logic held_len_zero;
		logic xor_ok;
		logic fill_done;
		logic timeout_hit;
		logic read_last;
	} dp_status_t;

endpackage
`default_nettype wire

[design/stx_etx_packet_receiver_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stx_etx_packet_receiver_unit
// Framed packet receiver: start marker, command, length, payload, XOR check
// byte and end marker, with timeout, error reporting and statistics.
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_stall/in_data carry one transaction per byte, tick or clear.
//   out_valid/out_stall/out_data carry result transactions from one output
//   register; a good packet gives one result per payload byte (or one empty
//   result), an error gives one result.
//   cfg_write/cfg_index/cfg_data write start marker, end marker and timeout
//   limit; write them only while the block is idle.
//   an input transaction is accepted, then executed in the controller; an
//   immediate result is loaded in the execute step and shows on out_valid
//   from the result register. a good packet's payload is then read from
//   the payload store byte by byte, each in a read and an emit step, and
//   the next transaction is accepted only after the last byte is emitted.
//   a stalled receiver holds the result register; the block still takes
//   a transaction and waits only when a new result has nowhere to go.
//   reset restores configuration defaults, clears counters and parser and
//   empties the output register; the payload store needs no clearing.
// ----------------------------------------------------------------------------
module stx_etx_packet_receiver_unit
	import stxrx_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire rx_item_t                 in_data,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output rx_result_t                    out_data,
	input  wire logic                     cfg_write,
	input  wire logic [CfgIndexWidth-1:0] cfg_index,
	input  wire logic [CfgDataWidth-1:0]  cfg_data
);

	dp_cmd_t    ctrl_cmd;
	dp_status_t dp_sts;

	stxrx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (dp_sts),
		.cmd      (ctrl_cmd)
	);

	stxrx_dp #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (ctrl_cmd),
		.sts      (dp_sts),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	// a result is never loaded over one that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	// results are produced only after the accept cycle
	a_no_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !ctrl_cmd.out_load)
		else $error("result loaded in the accept cycle");

	// payload byte results stay inside their packet
	a_index_in_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_BYTE) |->
			({1'b0, out_data.byte_index} < out_data.length))
		else $error("byte index beyond packet length");

	// empty and error results always close their run
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind != KIND_BYTE) |-> out_data.last)
		else $error("single result without last");
`endif

endmodule
`default_nettype wire

[design/stxrx_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stxrx_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module stxrx_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64,
	localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [AddrWidth-1:0] wr_addr,
	input  wire logic [Width-1:0]     wr_data,
	input  wire logic [AddrWidth-1:0] rd_addr,
	output logic      [Width-1:0]     rd_data
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

[design/stxrx_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stxrx_dp
// Receiver datapath: configuration, packet fields, checksum, timer,
// statistics counters, payload store and the result register.
// ----------------------------------------------------------------------------
module stxrx_dp
	import stxrx_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic [CfgIndexWidth-1:0] cfg_index,
	input  wire logic [CfgDataWidth-1:0]  cfg_data,
	input  wire rx_item_t                 in_data,
	input  wire dp_cmd_t                  cmd,
	output dp_status_t                    sts,
	output rx_result_t                    out_data
);

	localparam int unsigned AddrWidth = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [7:0] LenLimit = 8'(MAX_PAYLOAD);

	logic [7:0]             start_q;
	logic [7:0]             end_q;
	logic [15:0]            limit_q;
	rx_item_t               item_q;
	logic [7:0]             held_cmd_q;
	logic [LengthWidth-1:0] held_len_q;
	logic [LengthWidth-1:0] fill_q;
	logic [7:0]             xor_q;
	logic [7:0]             chk_q;
	logic [15:0]            elapsed_q;
	logic [IndexWidth-1:0]  rd_idx_q;
	logic [CountWidth-1:0]  good_q, chkerr_q, timeout_q, overrun_q;
	logic [CountWidth-1:0]  good_d, chkerr_d, timeout_d, overrun_d;
	rx_result_t             out_q;
	logic [7:0]             ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_MARKER_RST;
			end_q   <= END_MARKER_RST;
			limit_q <= TIMEOUT_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_START_MARKER:  start_q <= cfg_data[7:0];
				CFG_END_MARKER:    end_q   <= cfg_data[7:0];
				CFG_TIMEOUT_LIMIT: limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_data;
		end
	end

	// packet fields and timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cmd_q <= '0;
			held_len_q <= '0;
			fill_q     <= '0;
			xor_q      <= '0;
			chk_q      <= '0;
			elapsed_q  <= '0;
			rd_idx_q   <= '0;
		end else begin
			if (cmd.start_pkt) begin
				elapsed_q <= '0;
			end else if (cmd.tick_inc) begin
				elapsed_q <= elapsed_q + 16'd1;
			end
			if (cmd.load_cmd) begin
				held_cmd_q <= item_q.rx_byte;
				xor_q      <= item_q.rx_byte;
			end
			if (cmd.load_len) begin
				held_len_q <= item_q.rx_byte[LengthWidth-1:0];
				xor_q      <= xor_q ^ item_q.rx_byte;
				fill_q     <= '0;
			end
			if (cmd.write_data) begin
				xor_q  <= xor_q ^ item_q.rx_byte;
				fill_q <= fill_q + 7'd1;
			end
			if (cmd.load_chk) begin
				chk_q <= item_q.rx_byte;
			end
			if (cmd.rd_start) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_next) begin
				rd_idx_q <= rd_idx_q + 6'd1;
			end
		end
	end

	// counters, next values also feed the result register
	always_comb begin
		good_d    = good_q;
		chkerr_d  = chkerr_q;
		timeout_d = timeout_q;
		overrun_d = overrun_q;
		if (cmd.clear_stats) begin
			good_d    = '0;
			chkerr_d  = '0;
			timeout_d = '0;
			overrun_d = '0;
		end else begin
			if (cmd.inc_good)    good_d    = good_q + 32'd1;
			if (cmd.inc_chkerr)  chkerr_d  = chkerr_q + 32'd1;
			if (cmd.inc_timeout) timeout_d = timeout_q + 32'd1;
			if (cmd.inc_overrun) overrun_d = overrun_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_q    <= '0;
			chkerr_q  <= '0;
			timeout_q <= '0;
			overrun_q <= '0;
		end else begin
			good_q    <= good_d;
			chkerr_q  <= chkerr_d;
			timeout_q <= timeout_d;
			overrun_q <= overrun_d;
		end
	end

	stxrx_ram #(
		.Width(8),
		.Depth(MAX_PAYLOAD)
	) u_store (
		.clk    (clk),
		.wr_en  (cmd.write_data),
		.wr_addr(fill_q[AddrWidth-1:0]),
		.wr_data(item_q.rx_byte),
		.rd_addr(rd_idx_q[AddrWidth-1:0]),
		.rd_data(ram_rdata)
	);

	always_comb begin
		sts.operation     = item_q.operation;
		sts.byte_is_start = (item_q.rx_byte == start_q);
		sts.byte_is_end   = (item_q.rx_byte == end_q);
		sts.byte_over     = (item_q.rx_byte > LenLimit);
		sts.byte_zero     = (item_q.rx_byte == 8'd0);
		sts.held_len_zero = (held_len_q == '0);
		sts.xor_ok        = (xor_q == chk_q);
		sts.fill_done     = ((fill_q + 7'd1) >= held_len_q);
		sts.timeout_hit   = (elapsed_q >= limit_q);
		sts.read_last     = (({1'b0, rd_idx_q} + 7'd1) == held_len_q);
	end

	// result register, error results carry zeroed packet fields
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.kind                 <= cmd.out_kind;
			out_q.received_count       <= good_d;
			out_q.checksum_error_count <= chkerr_d;
			out_q.timeout_count        <= timeout_d;
			out_q.overrun_count        <= overrun_d;
			unique case (cmd.out_kind)
				KIND_BYTE: begin
					out_q.command      <= held_cmd_q;
					out_q.length       <= held_len_q;
					out_q.byte_index   <= rd_idx_q;
					out_q.payload_byte <= ram_rdata;
					out_q.last         <= sts.read_last;
				end
				KIND_EMPTY: begin
					out_q.command      <= held_cmd_q;
					out_q.length       <= '0;
					out_q.byte_index   <= '0;
					out_q.payload_byte <= '0;
					out_q.last         <= 1'b1;
				end
				default: begin
					out_q.command      <= '0;
					out_q.length       <= '0;
					out_q.byte_index   <= '0;
					out_q.payload_byte <= '0;
					out_q.last         <= 1'b1;
				end
			endcase
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

[design/stxrx_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stxrx_ctrl
// Receiver controller: transaction sequencer, packet parse phase and
// result register valid flag.
// ----------------------------------------------------------------------------
module stxrx_ctrl
	import stxrx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire dp_status_t sts,
	output dp_cmd_t         cmd
);

	seq_t   seq_q, seq_d;
	phase_t phase_q, phase_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (seq_q != SQ_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SQ_IDLE;
			phase_q     <= PH_HUNT;
			out_valid_q <= 1'b0;
		end else begin
			seq_q   <= seq_d;
			phase_q <= phase_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd     = '0;
		seq_d   = seq_q;
		phase_d = phase_q;
		unique case (seq_q)
			SQ_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					seq_d         = SQ_EXEC;
				end
			end
			SQ_EXEC: begin
				seq_d = SQ_IDLE;
				unique case (sts.operation)
					OP_BYTE: begin
						unique case (phase_q)
							PH_HUNT: begin
								if (sts.byte_is_start) begin
									cmd.start_pkt = 1'b1;
									phase_d       = PH_CMD;
								end
							end
							PH_CMD: begin
								cmd.load_cmd = 1'b1;
								phase_d      = PH_LEN;
							end
							PH_LEN: begin
								if (sts.byte_over) begin
									if (slot_free) begin
										cmd.inc_overrun = 1'b1;
										cmd.out_load    = 1'b1;
										cmd.out_kind    = KIND_OVERRUN;
										phase_d         = PH_HUNT;
									end else begin
										seq_d = SQ_EXEC;
									end
								end else begin
									cmd.load_len = 1'b1;
									phase_d      = sts.byte_zero ? PH_CHK : PH_DATA;
								end
							end
							PH_DATA: begin
								cmd.write_data = 1'b1;
								if (sts.fill_done) begin
									phase_d = PH_CHK;
								end
							end
							PH_CHK: begin
								cmd.load_chk = 1'b1;
								phase_d      = PH_END;
							end
							PH_END: begin
								if (!sts.byte_is_end || !sts.xor_ok || sts.held_len_zero) begin
									// these outcomes give one result directly, once the result register is free
									if (slot_free) begin
										cmd.out_load = 1'b1;
										phase_d      = PH_HUNT;
										priority if (!sts.byte_is_end) begin
											cmd.out_kind = KIND_BADEND;
										end else if (!sts.xor_ok) begin
											cmd.inc_chkerr = 1'b1;
											cmd.out_kind   = KIND_CHKERR;
										end else begin
											cmd.inc_good = 1'b1;
											cmd.out_kind = KIND_EMPTY;
										end
									end else begin
										seq_d = SQ_EXEC;
									end
								end else begin
									cmd.inc_good = 1'b1;
									cmd.rd_start = 1'b1;
									phase_d      = PH_HUNT;
									seq_d        = SQ_READ;
								end
							end
							default: begin
								phase_d = PH_HUNT;
							end
						endcase
					end
					OP_TICK: begin
						if (phase_q != PH_HUNT) begin
							if (sts.timeout_hit) begin
								if (slot_free) begin
									cmd.inc_timeout = 1'b1;
									cmd.out_load    = 1'b1;
									cmd.out_kind    = KIND_TIMEOUT;
									phase_d         = PH_HUNT;
								end else begin
									seq_d = SQ_EXEC;
								end
							end else begin
								cmd.tick_inc = 1'b1;
							end
						end
					end
					OP_CLEAR: begin
						cmd.clear_stats = 1'b1;
					end
					default: ;
				endcase
			end
			SQ_READ: begin
				// store read data is registered, valid in the next cycle
				seq_d = SQ_EMIT;
			end
			SQ_EMIT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_BYTE;
					if (sts.read_last) begin
						seq_d = SQ_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
						seq_d       = SQ_READ;
					end
				end
			end
			default: begin
				seq_d = SQ_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire
